// ----- hdl/ajbf_pkg.sv -----
// shared constants for the stereo jitter buffer with fade concealment
// item modes, register indexes, reset values and default sizes
// no dependencies
`default_nettype none

package ajbf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DECAY_W  = 16;
    localparam int FADE_W   = 32;
    localparam int THR_W    = 16;
    localparam int FRAMES_W = 6;
    localparam int MODE_W   = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 2;

    localparam int DEPTH_DEFAULT      = 65536;
    localparam int MAX_FRAMES_DEFAULT = 32;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_PREROLL = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DECAY   = 1'd1;

    localparam logic [THR_W-1:0]   PREROLL_RESET = 16'd768;
    localparam logic [DECAY_W-1:0] DECAY_RESET   = 16'd61604;

endpackage

`default_nettype wire

// ----- hdl/ajbf_ram.sv -----
// generic single-clock ram, one write port and one read port
// read data registered; no dependencies
`default_nettype none

module ajbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/audio_jitter_buffer_with_fade.sv -----
// stereo jitter buffer with fade concealment: ring of interleaved samples
// in one ajbf_ram, read requests stream out buffered, faded or zero samples
// depends on ajbf_pkg and ajbf_ram
//
// usage: the slave stream carries one item per transfer, its kind in tuser
// (write one sample, read request, clear). writes and clears finish in the
// cycle they are taken and give nothing out. a read of n frames (capped at
// MAX_FRAMES) gives 2n samples on the master stream, tlast on the final one,
// tuser marking channel and concealment. buffered samples leave one per cycle
// while the receiver keeps up, straight from the ram read port (the read
// address is the next read pointer, so no wait before the first one). each
// faded frame has a step for the two decay multiplies, then one per sample.
// zero fills go one per cycle while the receiver keeps up. the next item is
// taken in the cycle after its last sample enters the output register.
// the output register parts the two sides: when the receiver stalls, the
// block holds that sample and waits; the input side waits until the request
// is done. reset clears pointers, fade values, primed flag and registers;
// the sample ram is not cleared, as only written entries are ever read.
// configuration writes to the register file must come while the block is idle; the block does not enforce this.
`default_nettype none

module audio_jitter_buffer_with_fade #(
    parameter int DEPTH      = ajbf_pkg::DEPTH_DEFAULT,
    parameter int MAX_FRAMES = ajbf_pkg::MAX_FRAMES_DEFAULT
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration
    input  wire                                 i_cfg_we,
    input  wire [ajbf_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire [ajbf_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // input items
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire [ajbf_pkg::S_TDATA_W-1:0]       i_s_axis_tdata,  // sample_in[15:0], frames[21:16]
    input  wire [ajbf_pkg::MODE_W-1:0]          i_s_axis_tuser,  // mode[1:0]
    // output samples
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    output logic [ajbf_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,  // sample_out[15:0]
    output logic [ajbf_pkg::M_TUSER_W-1:0]      o_m_axis_tuser,  // channel[0], concealed[1]
    output logic                                o_m_axis_tlast
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int FR_W  = $clog2(MAX_FRAMES + 1);
    localparam int CNT_W = FR_W + 1;
    localparam int CMP_W = (PTR_W > ajbf_pkg::THR_W) ? PTR_W : ajbf_pkg::THR_W;
    localparam int SW    = ajbf_pkg::SAMPLE_W;
    localparam int FW    = ajbf_pkg::FADE_W;
    localparam int DW    = ajbf_pkg::DECAY_W;

    localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]     DEPTH_EXT = (PTR_W+1)'(DEPTH);
    localparam logic [FR_W-1:0]    FR_MAX    = FR_W'(MAX_FRAMES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BUF    = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_FADE_L = 3'd3;
    localparam logic [2:0] S_FADE_R = 3'd4;
    localparam logic [2:0] S_ZERO   = 3'd5;

    // control and config state
    logic [2:0]                r_state, n_state;
    logic [PTR_W-1:0]          r_wp, n_wp;
    logic [PTR_W-1:0]          r_rp, n_rp;
    logic                      r_primed, n_primed;
    logic [ajbf_pkg::THR_W-1:0] r_thr;
    logic [DW-1:0]             r_decay;
    logic [CNT_W-1:0]          r_k, n_k;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_take, n_take;
    // fades in sign and magnitude form
    logic                      r_fl_neg, n_fl_neg, r_fr_neg, n_fr_neg;
    logic [FW-1:0]             r_fl_mag, n_fl_mag, r_fr_mag, n_fr_mag;
    // output register
    logic                      r_o_valid, n_o_valid;
    logic [SW-1:0]             r_o_data, n_o_data;
    logic                      r_o_chan, n_o_chan;
    logic                      r_o_conc, n_o_conc;
    logic                      r_o_last, n_o_last;

    logic                      w_accept;
    logic                      w_out_free;
    logic                      w_load;
    logic                      w_last;
    logic [PTR_W-1:0]          w_fill;
    logic [PTR_W:0]            w_fill_ext;
    logic [CMP_W:0]            w_fill_cmp;
    logic [FR_W-1:0]           w_frames_sat;
    logic [CNT_W-1:0]          w_req_count;
    logic [CNT_W-1:0]          w_take;
    logic                      w_ram_we;
    logic [SW-1:0]             w_rdata;
    logic [SW:0]               w_rmag;
    logic [FW+DW-1:0]          w_prod_l, w_prod_r;
    logic [SW-1:0]             w_fade_smp;
    logic                      w_fade_neg;
    logic [FW-1:0]             w_fade_mag;
    logic [5:0]                w_frames_in;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_o_valid || i_m_axis_tready;
    assign w_last     = (r_k + CNT_W'(1)) == r_count;
    assign w_frames_in = i_s_axis_tdata[21:16];

    assign w_fill_ext = (r_wp >= r_rp) ? ({1'b0, r_wp} - {1'b0, r_rp})
                                       : ({1'b0, r_wp} + DEPTH_EXT - {1'b0, r_rp});
    assign w_fill = w_fill_ext[PTR_W-1:0];
    assign w_fill_cmp = (CMP_W+1)'(w_fill);

    assign w_frames_sat = ({1'b0, w_frames_in} > {1'b0, 6'(MAX_FRAMES)}) ? FR_MAX
                                                                         : FR_W'(w_frames_in);
    assign w_req_count = {w_frames_sat, 1'b0};
    assign w_take = (w_fill_cmp >= (CMP_W+1)'(w_req_count))
                  ? {w_req_count[CNT_W-1:1], 1'b0}
                  : {w_fill_cmp[CNT_W-1:1], 1'b0};

    assign w_ram_we = w_accept && (i_s_axis_tuser == ajbf_pkg::MODE_WRITE)
                   && (w_fill != PTR_LAST);

    ajbf_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_s_axis_tdata[SW-1:0]),
        .i_raddr (n_rp),
        .o_rdata (w_rdata)
    );

    // magnitude of the buffered sample, for the fade capture
    assign w_rmag = w_rdata[SW-1] ? ((SW+1)'(0) - {w_rdata[SW-1], w_rdata})
                                  : {1'b0, w_rdata};

    assign w_prod_l = (FW+DW)'(r_fl_mag) * (FW+DW)'(r_decay);
    assign w_prod_r = (FW+DW)'(r_fr_mag) * (FW+DW)'(r_decay);

    assign w_fade_neg = (r_state == S_FADE_R) ? r_fr_neg : r_fl_neg;
    assign w_fade_mag = (r_state == S_FADE_R) ? r_fr_mag : r_fl_mag;
    assign w_fade_smp = w_fade_neg ? (SW'(0) - w_fade_mag[FW-1:FW-SW]) : w_fade_mag[FW-1:FW-SW];

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_primed  = r_primed;
        n_k       = r_k;
        n_count   = r_count;
        n_take    = r_take;
        n_fl_neg  = r_fl_neg;
        n_fl_mag  = r_fl_mag;
        n_fr_neg  = r_fr_neg;
        n_fr_mag  = r_fr_mag;
        n_o_valid = r_o_valid && !i_m_axis_tready;
        n_o_data  = r_o_data;
        n_o_chan  = r_o_chan;
        n_o_conc  = r_o_conc;
        n_o_last  = r_o_last;
        w_load    = 1'b0;

        unique case (r_state) inside
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_s_axis_tuser)
                        ajbf_pkg::MODE_WRITE: begin
                            if (w_fill != PTR_LAST) begin
                                n_wp = (r_wp == PTR_LAST) ? '0 : r_wp + PTR_W'(1);
                            end
                        end
                        ajbf_pkg::MODE_CLEAR: begin
                            n_wp     = '0;
                            n_rp     = '0;
                            n_primed = 1'b0;
                            n_fl_neg = 1'b0;
                            n_fl_mag = '0;
                            n_fr_neg = 1'b0;
                            n_fr_mag = '0;
                        end
                        ajbf_pkg::MODE_READ: begin
                            if (w_frames_in != 6'd0) begin
                                n_k     = '0;
                                n_count = w_req_count;
                                n_take  = w_take;
                                if (!r_primed && ((CMP_W)'(w_fill) < (CMP_W)'(r_thr))) begin
                                    n_state = S_ZERO;
                                end else if (w_fill == '0) begin
                                    // underrun drops back to waiting for preroll
                                    n_primed = 1'b0;
                                    n_state  = S_ZERO;
                                end else begin
                                    n_primed = 1'b1;
                                    n_state  = (w_take == '0) ? S_MUL : S_BUF;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_BUF: begin
                if (w_out_free) begin
                    w_load    = 1'b1;
                    n_o_data  = w_rdata;
                    n_o_conc  = 1'b0;
                    n_rp      = (r_rp == PTR_LAST) ? '0 : r_rp + PTR_W'(1);
                    n_k       = r_k + CNT_W'(1);
                    if (r_k[0]) begin
                        n_fr_neg = w_rdata[SW-1];
                        n_fr_mag = {w_rmag[FW-SW-1:0], 16'd0};
                    end else begin
                        n_fl_neg = w_rdata[SW-1];
                        n_fl_mag = {w_rmag[FW-SW-1:0], 16'd0};
                    end
                    if (n_k == r_take) begin
                        n_state = (r_take == r_count) ? S_IDLE : S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_fl_mag = w_prod_l[FW+DW-1:DW];
                n_fr_mag = w_prod_r[FW+DW-1:DW];
                n_state  = S_FADE_L;
            end
            S_FADE_L, S_FADE_R: begin
                if (w_out_free) begin
                    w_load   = 1'b1;
                    n_o_data = w_fade_smp;
                    n_o_conc = 1'b1;
                    n_k      = r_k + CNT_W'(1);
                    if (r_state == S_FADE_L) begin
                        n_state = S_FADE_R;
                    end else begin
                        n_state = w_last ? S_IDLE : S_MUL;
                    end
                end
            end
            S_ZERO: begin
                if (w_out_free) begin
                    w_load   = 1'b1;
                    n_o_data = '0;
                    n_o_conc = 1'b1;
                    n_k      = r_k + CNT_W'(1);
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_o_valid = 1'b1;
            n_o_chan  = r_k[0];
            n_o_last  = w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_rp      <= '0;
            r_primed  <= 1'b0;
            r_k       <= '0;
            r_count   <= '0;
            r_take    <= '0;
            r_fl_neg  <= 1'b0;
            r_fl_mag  <= '0;
            r_fr_neg  <= 1'b0;
            r_fr_mag  <= '0;
            r_o_valid <= 1'b0;
            r_thr     <= ajbf_pkg::PREROLL_RESET;
            r_decay   <= ajbf_pkg::DECAY_RESET;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_primed  <= n_primed;
            r_k       <= n_k;
            r_count   <= n_count;
            r_take    <= n_take;
            r_fl_neg  <= n_fl_neg;
            r_fl_mag  <= n_fl_mag;
            r_fr_neg  <= n_fr_neg;
            r_fr_mag  <= n_fr_mag;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    ajbf_pkg::REG_PREROLL: r_thr   <= i_cfg_wdata[ajbf_pkg::THR_W-1:0];
                    ajbf_pkg::REG_DECAY:   r_decay <= i_cfg_wdata[DW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // output payload needs no reset
    always_ff @(posedge i_clk) begin
        r_o_data <= n_o_data;
        r_o_chan <= n_o_chan;
        r_o_conc <= n_o_conc;
        r_o_last <= n_o_last;
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = {r_o_conc, r_o_chan};
    assign o_m_axis_tlast  = r_o_last;

    // buffered samples are only taken while the ring holds data
    a_buf_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BUF) |-> (w_fill != '0))
        else $error("buffered read from an empty ring");

    // the sample index stays inside the request while busy
    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_k < r_count))
        else $error("sample index past the request");

    // the final sample of a request returns the block to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_state == S_IDLE))
        else $error("request did not end on its last sample");

    // a clear empties the ring and drops the primed flag
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_s_axis_tuser == ajbf_pkg::MODE_CLEAR))
        |=> (!r_primed && (r_wp == '0) && (r_rp == '0)))
        else $error("clear left state behind");

    // fades are only produced after all buffered frames are out
    a_fade_after_buf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FADE_L) || (r_state == S_FADE_R)) |-> (r_k >= r_take))
        else $error("fade sample before buffered data was drained");

endmodule

`default_nettype wire
